// ===== design/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Types, codes and sizing constants shared by the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	// arena geometry
	localparam int ARENA_BYTES  = 512;
	localparam int HEADER_BYTES = 8;
	localparam int MAX_BLOCKS   = 64;

	// field widths
	localparam int LEN_W = 9;   // request_size and stored block length
	localparam int OFS_W = 10;  // handle, payload offset and tail offset
	localparam int SUM_W = OFS_W + 1;

	// block table sizing
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int ENT_W = LEN_W + 1;  // busy mark over length

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_IGNORED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_RESP
	} state_t;

	typedef struct packed {
		cmd_code_t        command;
		logic [LEN_W-1:0] request_size;
		logic [OFS_W-1:0] handle;
	} cmd_t;

	typedef struct packed {
		logic [OFS_W-1:0] payload_offset;
		status_t          status;
	} res_t;

endpackage

// ===== design/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a fixed arena of non-splitting blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on cmd (cmd_valid / cmd_stall); each gives exactly one
//   response on res (res_valid / res_stall). An allocate walks the formed
//   blocks from the start and takes the first free one that fits, else forms
//   a new block at the tail; a free clears the busy mark of the block whose
//   payload starts at the handle.
//   The walk reads one block entry per cycle from the block table RAM,
//   taking the formed blocks in order and stopping early at a fitting
//   block or at the handle. After the response is taken the block returns
//   to idle, where the next request is taken. One request is in flight at a
//   time: cmd_stall is high from acceptance until the response has been
//   taken. The response register holds while res_stall is high.
//   Reset empties the arena at once: the block count and tail offset clear,
//   and table entries are only read below the block count, so no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  ffba_pkg::cmd_t  cmd,
	output logic            res_valid,
	input  logic            res_stall,
	output ffba_pkg::res_t  res
);
	import ffba_pkg::*;

	localparam logic [SUM_W-1:0] HDR_S   = SUM_W'(HEADER_BYTES);
	localparam logic [SUM_W-1:0] ARENA_S = SUM_W'(ARENA_BYTES);
	localparam logic [CNT_W-1:0] MAX_C   = CNT_W'(MAX_BLOCKS);

	state_t           state_q, state_nxt;
	cmd_t             cmd_q;
	res_t             res_q, res_nxt;
	logic [CNT_W-1:0] count_q, k_q, k_inc;
	logic [OFS_W-1:0] tail_q, off_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	logic [ENT_W-1:0] ram_wdata, ram_rdata;

	logic             ent_busy;
	logic [LEN_W-1:0] ent_len;
	logic             in_range, alloc_fit, free_match, tail_ok, finish;
	logic [SUM_W-1:0] off_hdr, off_next, tail_sum;

	// block table: busy mark and payload length per formed block
	ffba_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// decode the current entry and the walk conditions
	assign ent_busy   = ram_rdata[LEN_W];
	assign ent_len    = ram_rdata[LEN_W-1:0];
	assign k_inc      = k_q + 1'b1;
	assign in_range   = (k_q < count_q);
	assign off_hdr    = {1'b0, off_q} + HDR_S;
	assign off_next   = off_hdr + SUM_W'(ent_len);
	assign tail_sum   = {1'b0, tail_q} + HDR_S + SUM_W'(cmd_q.request_size);
	assign alloc_fit  = !ent_busy && (cmd_q.request_size <= ent_len);
	assign free_match = (off_hdr == {1'b0, cmd_q.handle});
	assign tail_ok    = (count_q < MAX_C) && (tail_sum <= ARENA_S);
	assign finish     = (state_q == S_WALK) &&
	                    (!in_range || ((cmd_q.command == CMD_ALLOC) ? alloc_fit : free_match));

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) state_nxt = S_WALK;
			end
			S_WALK: begin
				if (finish) state_nxt = S_RESP;
			end
			S_RESP: begin
				if (!res_stall) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs: table access and response selection
	always_comb begin
		cmd_stall = (state_q != S_IDLE);
		res_valid = (state_q == S_RESP);
		res       = res_q;
		ram_raddr = (state_q == S_IDLE) ? '0 : k_inc[IDX_W-1:0];
		ram_we    = 1'b0;
		ram_waddr = k_q[IDX_W-1:0];
		ram_wdata = {1'b1, ent_len};
		res_nxt   = '{payload_offset: '0, status: ST_IGNORED};
		if (in_range) begin
			if (cmd_q.command == CMD_ALLOC) begin
				res_nxt = '{payload_offset: off_hdr[OFS_W-1:0], status: ST_DONE};
				ram_we  = finish;
			end else begin
				res_nxt   = '{payload_offset: '0, status: ST_DONE};
				ram_wdata = {1'b0, ent_len};
				ram_we    = finish;
			end
		end else if (cmd_q.command == CMD_ALLOC) begin
			ram_waddr = count_q[IDX_W-1:0];
			ram_wdata = {1'b1, cmd_q.request_size};
			if (tail_ok) begin
				res_nxt = '{payload_offset: OFS_W'(tail_q + OFS_W'(HEADER_BYTES)),
				            status: ST_DONE};
				ram_we  = finish;
			end else begin
				res_nxt = '{payload_offset: '0, status: ST_NOSPACE};
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			tail_q  <= '0;
		end else begin
			state_q <= state_nxt;
			// form a new block at the tail
			if (finish && !in_range && cmd_q.command == CMD_ALLOC && tail_ok) begin
				count_q <= count_q + 1'b1;
				tail_q  <= tail_sum[OFS_W-1:0];
			end
		end
	end

	// walk position, captured request and response
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			cmd_q <= cmd;
			k_q   <= '0;
			off_q <= '0;
		end else if (state_q == S_WALK) begin
			if (finish) begin
				res_q <= res_nxt;
			end else begin
				k_q   <= k_inc;
				off_q <= off_next[OFS_W-1:0];
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_C)
		else $error("block count beyond table depth");

	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, tail_q} <= ARENA_S)
		else $error("tail offset beyond arena");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (k_q <= count_q))
		else $error("walk ran past the formed blocks");

	a_nospace_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == ST_NOSPACE) |-> (res.payload_offset == '0))
		else $error("failed allocation returned an offset");

	a_resp_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall) |=> (!res_valid && !cmd_stall))
		else $error("block not idle after response taken");
`endif

endmodule

// ===== test/first_fit_block_allocator_test.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_test
// Self-checking bench for the first-fit block allocator. A directed table
// covers the reset state, the size and handle extremes, reuse, skipped blocks
// and ignored frees. Random allocate and free traffic follows, with random
// gaps on the request side and random stalls on the response side. Each
// response is checked against a behavioral copy of the block table, or against the value given in a directed row.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_test;
	import ffba_pkg::*;

	localparam int RANDOM_ITEMS   = 1100;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 80;

	typedef struct {
		cmd_t req;
		bit   typed;
		res_t want;
	} dir_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd       = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	// behavioral copy of the block table
	int arena_len [MAX_BLOCKS];
	bit arena_busy[MAX_BLOCKS];
	int arena_count;
	int arena_tail;
	int peak_blocks;

	res_t     pending_res[$];
	dir_row_t dir_rows[$];

	bit quiet = 1'b0;
	int idle_cycles = 0;
	int stall_left  = 0;
	int mismatches  = 0;
	int sent        = 0;
	int checked     = 0;
	int granted     = 0;
	int refused     = 0;
	int ignored_cnt = 0;

	first_fit_block_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #2 clk = ~clk;

	// Apply one request to the table copy and return the response it gives.
	function automatic res_t serve_request(cmd_t c);
		res_t r;
		int   ofs;
		int   size;
		ofs  = 0;
		size = int'(c.request_size);
		r.payload_offset = '0;
		if (c.command == CMD_ALLOC) begin
			r.status = ST_NOSPACE;
			for (int k = 0; k < arena_count; k++) begin
				if (!arena_busy[k] && size <= arena_len[k]) begin
					arena_busy[k]    = 1'b1;
					r.payload_offset = OFS_W'(ofs + HEADER_BYTES);
					r.status         = ST_DONE;
					return r;
				end
				ofs += HEADER_BYTES + arena_len[k];
			end
			// form a new block at the tail if a slot and the bytes are left
			if (arena_count < MAX_BLOCKS && arena_tail + HEADER_BYTES + size <= ARENA_BYTES) begin
				arena_len[arena_count]  = size;
				arena_busy[arena_count] = 1'b1;
				r.payload_offset        = OFS_W'(arena_tail + HEADER_BYTES);
				r.status                = ST_DONE;
				arena_tail              = arena_tail + HEADER_BYTES + size;
				arena_count++;
				if (arena_count > peak_blocks)
					peak_blocks = arena_count;
			end
			return r;
		end
		r.status = ST_IGNORED;
		if (c.handle != '0) begin
			for (int k = 0; k < arena_count; k++) begin
				if (ofs + HEADER_BYTES == int'(c.handle)) begin
					arena_busy[k] = 1'b0;
					r.status      = ST_DONE;
					return r;
				end
				ofs += HEADER_BYTES + arena_len[k];
			end
		end
		return r;
	endfunction

	// Payload offset of formed block idx.
	function automatic int block_handle(int idx);
		int ofs;
		ofs = 0;
		for (int k = 0; k < idx; k++)
			ofs += HEADER_BYTES + arena_len[k];
		return ofs + HEADER_BYTES;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Mostly small allocations so many blocks form; frees mostly hit formed blocks.
	function automatic cmd_t make_random_request();
		cmd_t c;
		int   roll;
		c.request_size = LEN_W'($urandom);
		c.handle       = OFS_W'($urandom_range(0, ARENA_BYTES));
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			c.command = CMD_ALLOC;
			roll = $urandom_range(0, 99);
			if (roll < 50)
				c.request_size = LEN_W'($urandom_range(0, 2));
			else if (roll < 85)
				c.request_size = LEN_W'($urandom_range(3, 32));
			else if (roll < 97)
				c.request_size = LEN_W'($urandom_range(33, 150));
			else
				c.request_size = LEN_W'($urandom_range(151, 511));
		end else begin
			c.command = CMD_FREE;
			roll = $urandom_range(0, 99);
			if (roll < 80 && arena_count > 0)
				c.handle = OFS_W'(block_handle($urandom_range(0, arena_count - 1)));
			else if (roll < 90)
				c.handle = '0;
		end
		return c;
	endfunction

	function automatic void add_row(cmd_code_t op, int size, int hnd, bit typed = 1'b0,
			int ofs = 0, status_t st = ST_DONE);
		dir_row_t row;
		row.req   = '{op, LEN_W'(size), OFS_W'(hnd)};
		row.typed = typed;
		row.want  = '{OFS_W'(ofs), st};
		dir_rows.push_back(row);
	endfunction

	function automatic void note_failure(string msg);
		if (mismatches < 10)
			$display("ERROR: %s", msg);
		mismatches++;
	endfunction

	// Present one request after a random gap, hold it until taken, then predict.
	task automatic send_request(input cmd_t c, input bit typed, input res_t want);
		int   gap;
		res_t predicted;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (cmd_stall);
		predicted = serve_request(c);
		pending_res.push_back(typed ? want : predicted);
		sent++;
		@(negedge clk);
	endtask

	// Stall the response side in random runs, except in quiet stretches.
	always @(negedge clk) begin
		if (quiet) begin
			res_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left == 0) begin
			res_stall <= ($urandom_range(0, 2) == 0);
			stall_left = pick_gap() + 1;
		end else begin
			stall_left--;
		end
	end

	// Check each taken response against the oldest expected one.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_res.size() == 0) begin
				note_failure($sformatf("response with none expected: offset %0d status %0d",
					res.payload_offset, res.status));
			end else begin
				want = pending_res.pop_front();
				checked++;
				if (res.payload_offset !== want.payload_offset || res.status !== want.status)
					note_failure($sformatf("response %0d: expected offset %0d status %0d, got offset %0d status %0d",
						checked, want.payload_offset, want.status, res.payload_offset, res.status));
			end
			case (res.status)
				ST_DONE:    granted++;
				ST_NOSPACE: refused++;
				default:    ignored_cnt++;
			endcase
		end
	end

	// End the run if nothing is taken on either side for too long.
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("ERROR: no handshake for %0d cycles, %0d responses outstanding",
				WATCHDOG_LIMIT, pending_res.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < MAX_BLOCKS; k++) begin
			arena_len[k]  = 0;
			arena_busy[k] = 1'b0;
		end
		arena_count = 0;
		arena_tail  = 0;
		peak_blocks = 0;

		// directed table: empty arena, extremes, reuse, skipping, ignored frees
		add_row(CMD_FREE,  0,   0,   1'b1, 0, ST_IGNORED);  // null handle
		add_row(CMD_FREE,  0,   512, 1'b1, 0, ST_IGNORED);  // no blocks yet
		add_row(CMD_ALLOC, 511, 0,   1'b1, 0, ST_NOSPACE);  // never fits with header
		add_row(CMD_ALLOC, 0,   0,   1'b1, 8, ST_DONE);     // zero-size first block
		add_row(CMD_ALLOC, 16,  0);
		add_row(CMD_ALLOC, 4,   0);
		add_row(CMD_FREE,  0,   16);
		add_row(CMD_FREE,  0,   16);                        // already free
		add_row(CMD_ALLOC, 20,  0);                         // skips the 16-byte hole
		add_row(CMD_ALLOC, 10,  0);                         // reuses the hole
		add_row(CMD_FREE,  0,   8);
		add_row(CMD_ALLOC, 0,   0);                         // zero size takes any free block
		add_row(CMD_FREE,  0,   9,   1'b1, 0, ST_IGNORED);  // not a payload start
		add_row(CMD_FREE,  0,   1,   1'b1, 0, ST_IGNORED);
		add_row(CMD_ALLOC, 256, 0);
		add_row(CMD_FREE,  0,   80);
		add_row(CMD_ALLOC, 300, 0);                         // hole too small, tail too short
		add_row(CMD_ALLOC, 200, 0);
		add_row(CMD_ALLOC, 511, 1023, 1'b1, 0, ST_NOSPACE);
		add_row(CMD_FREE,  511, 512);
		add_row(CMD_FREE,  0,   80);
		add_row(CMD_ALLOC, 255, 0);
		add_row(CMD_FREE,  0,   80);

		// hold reset, then release between edges
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

		// random traffic, with a stretch of back-to-back requests every 512
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = ((n / 128) % 4) == 2;
			send_request(make_random_request(), 1'b0, '0);
		end
		cmd_valid <= 1'b0;
		quiet = 1'b0;

		// drain, then watch for stray responses
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d directed), checked %0d responses, %0d mismatches.",
			sent, dir_rows.size(), checked, mismatches);
		$display("Responses: %0d done, %0d out of space, %0d ignored; up to %0d blocks formed.",
			granted, refused, ignored_cnt, peak_blocks);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
design/ffba_pkg.sv
design/ffba_ram.sv
design/first_fit_block_allocator.sv
test/first_fit_block_allocator_test.sv
